// ===== design/mfs_pkg.sv =====
// ---------------------------------------------------------------------------
// mfs_pkg
// Types, constants and signature tables for the module format sniffer.
// ---------------------------------------------------------------------------
`default_nettype none

package mfs_pkg;

  localparam int unsigned PosWidth = 11;

  localparam logic [PosWidth-1:0] POS_LIMIT   = 11'd1084;
  localparam logic [PosWidth-1:0] TAIL_START  = 11'd1080;
  localparam logic [PosWidth-1:0] S3M_OFFSET  = 11'd44;
  localparam logic [PosWidth-1:0] S3M_VER_OFS = 11'd29;
  localparam logic [PosWidth-1:0] PREFIX_LEN  = 11'd4;
  localparam logic [PosWidth-1:0] XM_LEN      = 11'd17;
  localparam logic [PosWidth-1:0] S3M_END     = 11'd48;

  localparam logic [7:0] S3M_VERSION = 8'h10;

  // Match flag bits; bit 4 is reserved and stays set.
  localparam int unsigned FlagIt  = 0;
  localparam int unsigned FlagS3m = 1;
  localparam int unsigned FlagXm  = 2;
  localparam int unsigned FlagMtm = 3;
  localparam logic [4:0] FLAGS_RESET = 5'b11111;

  typedef enum logic [2:0] {
    FMT_NONE = 3'd0,
    FMT_IT   = 3'd1,
    FMT_MOD  = 3'd2,
    FMT_S3M  = 3'd3,
    FMT_XM   = 3'd4,
    FMT_MTM  = 3'd5
  } fmt_kind_t;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       is_final;
  } in_item_t;

  typedef struct packed {
    logic       is_module;
    logic [2:0] format_kind;
  } out_item_t;

  typedef struct packed {
    logic [PosWidth-1:0] pos;
    logic [4:0]          flags;
    logic [31:0]         tail;
  } sniff_state_t;

  function automatic logic [7:0] it_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = "I";
      2'd1:    c = "M";
      2'd2:    c = "P";
      default: c = "M";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] mtm_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = "M";
      2'd1:    c = "T";
      2'd2:    c = "M";
      default: c = 8'h10;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] s3m_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = "S";
      2'd1:    c = "C";
      2'd2:    c = "R";
      default: c = "M";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] xm_char(input logic [4:0] idx);
    logic [7:0] c;
    case (idx)
      5'd0:    c = "E";
      5'd1:    c = "x";
      5'd2:    c = "t";
      5'd3:    c = "e";
      5'd4:    c = "n";
      5'd5:    c = "d";
      5'd6:    c = "e";
      5'd7:    c = "d";
      5'd8:    c = " ";
      5'd9:    c = "M";
      5'd10:   c = "o";
      5'd11:   c = "d";
      5'd12:   c = "u";
      5'd13:   c = "l";
      5'd14:   c = "e";
      5'd15:   c = ":";
      default: c = " ";
    endcase
    return c;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  // Four bytes at 1080, first byte on top.
  function automatic logic mod_match(input logic [31:0] t);
    logic [7:0] b0, b1, b2, b3;
    logic       two_dig, one_dig, mk;
    b0 = t[31:24];
    b1 = t[23:16];
    b2 = t[15:8];
    b3 = t[7:0];
    // channel count 01..32 written as two digits
    two_dig = (b2 == "C") && (b3 == "H") && is_digit(b1) &&
              (((b0 == "0") && (b1 != "0")) ||
               (b0 == "1") || (b0 == "2") ||
               ((b0 == "3") && (b1 <= "2")));
    one_dig = is_digit(b0) && (b1 == "C") && (b2 == "H") && (b3 == "N");
    mk      = (b0 == "M") && (b1 == ".") && (b2 == "K") && (b3 == ".");
    return two_dig || one_dig || mk;
  endfunction

endpackage

`default_nettype wire

// ===== design/mfs_step.sv =====
// ---------------------------------------------------------------------------
// mfs_step
// Per-byte state update and end-of-file format decision.
// ---------------------------------------------------------------------------
`default_nettype none

module mfs_step
  import mfs_pkg::*;
(
  input  sniff_state_t st,
  input  in_item_t     item,
  output sniff_state_t st_next,
  output out_item_t    result
);

  logic [7:0]          b;
  logic [PosWidth-1:0] pos;
  logic [PosWidth-1:0] len;
  logic [4:0]          flags;
  logic [31:0]         tail;
  fmt_kind_t           kind;

  always_comb begin
    b     = item.file_byte;
    pos   = st.pos;
    flags = st.flags;
    tail  = st.tail;

    if (pos < PREFIX_LEN) begin
      if (b != it_char(pos[1:0]))  flags[FlagIt]  = 1'b0;
      if (b != mtm_char(pos[1:0])) flags[FlagMtm] = 1'b0;
    end
    if ((pos < XM_LEN) && (b != xm_char(pos[4:0]))) flags[FlagXm] = 1'b0;
    if ((pos == S3M_VER_OFS) && (b != S3M_VERSION)) flags[FlagS3m] = 1'b0;
    // 44 is a multiple of four, so the low bits index the signature
    if ((pos >= S3M_OFFSET) && (pos < S3M_END) && (b != s3m_char(pos[1:0])))
      flags[FlagS3m] = 1'b0;
    if ((pos >= TAIL_START) && (pos < POS_LIMIT)) tail = {tail[23:0], b};

    len = (pos < POS_LIMIT) ? pos + 11'd1 : pos;

    if (flags[FlagIt] && (len >= PREFIX_LEN))           kind = FMT_IT;
    else if ((len >= POS_LIMIT) && mod_match(tail))      kind = FMT_MOD;
    else if (flags[FlagS3m] && (len >= S3M_END))         kind = FMT_S3M;
    else if (flags[FlagXm] && (len >= XM_LEN))           kind = FMT_XM;
    else if (flags[FlagMtm] && (len >= PREFIX_LEN))      kind = FMT_MTM;
    else                                                 kind = FMT_NONE;

    result.is_module   = (kind != FMT_NONE);
    result.format_kind = kind;

    if (item.is_final) begin
      st_next.pos   = '0;
      st_next.flags = FLAGS_RESET;
      st_next.tail  = '0;
    end else begin
      st_next.pos   = len;
      st_next.flags = flags;
      st_next.tail  = tail;
    end
  end

endmodule

`default_nettype wire

// ===== design/module_format_sniffer_core.sv =====
// ---------------------------------------------------------------------------
// module_format_sniffer_core
// Streams a file one byte per item and reports its tracker module format.
// ---------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid/in_ready/in_item): one file byte per item, from
//     offset zero; is_final marks the last byte of the file.
//   out channel (out_valid/out_ready/out_item): one item per file, raised
//     after the final byte: is_module and format_kind (first match among
//     IT, MOD, S3M, XM, MTM).
// Timing: a byte lands in the input register on the edge it is accepted;
//   a non-final byte is folded into the sniffer state on the next edge. A
//   final byte is folded in once the result slot is free, and its result
//   enters the output register at that same edge. One byte per cycle is
//   sustained unless a final byte waits, set by one compare-and-flag pass.
// Stalls: bytes that are not final never wait for the receiver. A final
//   byte waits in the input register while a previous result is still
//   unread; in_ready drops only when that register is blocked.
// Reset: clears both registers' valid bits and returns the sniffer to
//   offset zero with all match flags set. State also clears after every
//   final byte, so the next item starts a new file.
// ---------------------------------------------------------------------------
`default_nettype none

module module_format_sniffer_core
  import mfs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);

  // input register
  logic         s1_valid;
  in_item_t     s1_item;

  // sniffer state and step results
  sniff_state_t st;
  sniff_state_t st_next;
  out_item_t    result;

  logic         out_free;
  logic         s1_fire;

  mfs_step u_step (
    .st      (st),
    .item    (s1_item),
    .st_next (st_next),
    .result  (result)
  );

  // The result slot is free when empty or when its result is taken this cycle.
  assign out_free = !out_valid || out_ready;
  // Non-final bytes only touch state; final bytes need the result slot.
  assign s1_fire  = s1_valid && (!s1_item.is_final || out_free);
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.pos   <= '0;
      st.flags <= FLAGS_RESET;
      st.tail  <= '0;
    end else if (s1_fire) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_fire && s1_item.is_final;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_fire && s1_item.is_final) begin
      out_item <= result;
    end
  end

  // A result only ever comes from a final byte leaving the input register.
  a_result_from_final: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_fire && s1_item.is_final))
    else $error("result raised without a final byte");

  // After a final byte the sniffer is back at offset zero with flags set.
  a_restart_after_final: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_item.is_final) |=> (st.pos == '0 && st.flags == FLAGS_RESET))
    else $error("state not cleared after final byte");

  // Position advances by one per non-final byte until it saturates.
  a_pos_advance: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && !s1_item.is_final && st.pos < POS_LIMIT)
      |=> (st.pos == $past(st.pos) + 11'd1))
    else $error("byte position did not advance");

  // Position never runs past its saturation value.
  a_pos_limit: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> (st.pos <= POS_LIMIT))
    else $error("byte position beyond limit");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Bench for module_format_sniffer_core: streams whole files one byte per
// item, predicts the format verdict of each file, and checks every result.
// ---------------------------------------------------------------------------

module tb;
  import mfs_pkg::*;

  // Offsets of the signatures in a file
  localparam int SavedPosMax  = 1084;
  localparam int TailStart    = 1080;
  localparam int S3mVerOffset = 29;
  localparam int S3mOffset    = 44;
  localparam int PrefixLen    = 4;
  localparam int XmLen        = 17;

  // Match flag bits, one per prefix-style format
  localparam int HitIt  = 0;
  localparam int HitS3m = 1;
  localparam int HitXm  = 2;
  localparam int HitMtm = 3;

  localparam logic [7:0]   S3mVersion = 8'h10;
  localparam logic [31:0]  ItText     = "IMPM";
  localparam logic [31:0]  MtmText    = {"MTM", 8'h10};
  localparam logic [31:0]  ScrmText   = "SCRM";
  localparam logic [31:0]  MkText     = "M.K.";
  localparam logic [135:0] XmText     = "Extended Module: ";

  localparam int LenEdges [12] = '{3, 4, 5, 16, 17, 18, 29, 30, 44, 47, 48, 49};

  localparam int StallLimit  = 500;  // cycles with no item moving either way
  localparam int DrainCycles = 8;
  localparam int MainBytes   = 1450; // bytes before the last stretch

  // Byte i of an n-byte text, first character on top.
  function automatic logic [7:0] text_byte(input logic [135:0] txt, input int n,
                                           input int i);
    return txt[8*(n-1-i) +: 8];
  endfunction

  // Predicts the verdict of each file from its bytes and holds the verdicts
  // still owed by the block, oldest first.
  class sniff_scoreboard;
    logic [10:0] pos;
    logic [4:0]  flags;
    logic [31:0] tail;
    out_item_t   owed_verdicts[$];
    int          errors;

    function new();
      errors = 0;
      start_file();
    endfunction

    function void start_file();
      pos   = '0;
      flags = '1;
      tail  = '0;
    endfunction

    function int pending();
      return owed_verdicts.size();
    endfunction

    // Channel tag at offset 1080: "nnCH" with nn 1..32, "nCHN", or "M.K.".
    function bit tail_is_mod(input logic [31:0] t);
      logic [7:0] c0, c1, c2, c3;
      bit         dig0, dig1;
      int         chans;
      c0 = t[31:24];
      c1 = t[23:16];
      c2 = t[15:8];
      c3 = t[7:0];
      dig0 = (c0 >= 8'h30) && (c0 <= 8'h39);
      dig1 = (c1 >= 8'h30) && (c1 <= 8'h39);
      chans = (int'(c0) - 48) * 10 + (int'(c1) - 48);
      if (dig0 && dig1 && c2 == "C" && c3 == "H" && chans >= 1 && chans <= 32)
        return 1'b1;
      if (dig0 && c1 == "C" && c2 == "H" && c3 == "N")
        return 1'b1;
      return t == MkText;
    endfunction

    function void note_byte(input in_item_t it);
      logic [7:0] b;
      fmt_kind_t  kind;
      out_item_t  verdict;
      b = it.file_byte;
      if (pos < PrefixLen) begin
        if (b != text_byte(ItText, 4, pos)) flags[HitIt] = 1'b0;
        if (b != text_byte(MtmText, 4, pos)) flags[HitMtm] = 1'b0;
      end
      if (pos < XmLen && b != text_byte(XmText, 17, pos)) flags[HitXm] = 1'b0;
      if (pos == S3mVerOffset && b != S3mVersion) flags[HitS3m] = 1'b0;
      if (pos >= S3mOffset && pos < S3mOffset + 4 &&
          b != text_byte(ScrmText, 4, pos - S3mOffset))
        flags[HitS3m] = 1'b0;
      if (pos >= TailStart && pos < SavedPosMax) tail = {tail[23:0], b};
      if (pos < SavedPosMax) pos = pos + 11'd1;
      if (!it.is_final) return;

      // pos now holds the file length, up to the saturation point
      if (flags[HitIt] && pos >= PrefixLen)                   kind = FMT_IT;
      else if (pos >= SavedPosMax && tail_is_mod(tail))       kind = FMT_MOD;
      else if (flags[HitS3m] && pos >= S3mOffset + 4)         kind = FMT_S3M;
      else if (flags[HitXm] && pos >= XmLen)                  kind = FMT_XM;
      else if (flags[HitMtm] && pos >= PrefixLen)             kind = FMT_MTM;
      else                                                    kind = FMT_NONE;
      verdict.is_module   = (kind != FMT_NONE);
      verdict.format_kind = kind;
      owed_verdicts.push_back(verdict);
      start_file();
    endfunction

    function void check_result(input out_item_t got);
      out_item_t want;
      if (owed_verdicts.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, actual is_module %0b format_kind %0d",
                 $time, got.is_module, got.format_kind);
        return;
      end
      want = owed_verdicts.pop_front();
      if (got.is_module !== want.is_module) begin
        errors++;
        $display("%0t: is_module expected %0b actual %0b",
                 $time, want.is_module, got.is_module);
      end
      if (got.format_kind !== want.format_kind) begin
        errors++;
        $display("%0t: format_kind expected %0d actual %0d",
                 $time, want.format_kind, got.format_kind);
      end
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  sniff_scoreboard sb;
  logic [7:0]      file_bytes[$];   // file being built for the next send
  int              bytes_sent  = 0;
  int              in_idle_pct = 0; // chance of a gap before each byte
  bit              no_idling   = 1'b0;
  int              stall_cycles = 0;

  module_format_sniffer_core dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  always #4 clk = ~clk;

  // Handshakes are sampled in the active region of the edge, so they see
  // the values that held just before it. Results are checked before the
  // byte of the same edge is noted.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result(out_item);
      if (in_valid && in_ready) sb.note_byte(in_item);
    end
  end

  // Watchdog: a hung handshake on either side ends the run.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Receiver: stall bursts between ready stretches, some of them long;
  // always ready once the run is in its last part.
  initial begin
    forever begin
      if (no_idling || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 5) == 0) repeat ($urandom_range(40, 200)) @(posedge clk);
        else repeat ($urandom_range(1, 24)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
    end
  end

  // One byte item; an optional gap first. Returns in the step of acceptance.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (!no_idling && $urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_item.file_byte <= b;
    in_item.is_final  <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Directed file: the low n bytes of txt, first character on top.
  task automatic send_text(input logic [135:0] txt, input int n);
    for (int i = 0; i < n; i++) send_byte(text_byte(txt, n, i), i == n - 1);
  endtask

  task automatic send_built_file();
    in_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
    for (int i = 0; i < file_bytes.size(); i++)
      send_byte(file_bytes[i], i == file_bytes.size() - 1);
  endtask

  // Random file: noise with signatures laid over it, sometimes broken.
  // A long file runs up to or past the channel tag; short ones stay near
  // the head signatures and their length edges.
  task automatic build_random_file(input bit long_file);
    int         len;
    int         spot;
    logic [7:0] d0;
    logic [7:0] d1;
    logic [31:0] tag;
    if (long_file) len = $urandom_range(1083, 1110);
    else if ($urandom_range(0, 3) == 0) len = LenEdges[$urandom_range(0, 11)];
    else len = $urandom_range(1, 64);

    file_bytes.delete();
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0) file_bytes.push_back(8'h30 + 8'($urandom_range(0, 9)));
      else file_bytes.push_back(8'($urandom()));
    end

    // At most one head signature, since they collide at offset zero
    case ($urandom_range(0, 4))
      0: for (int i = 0; i < PrefixLen && i < len; i++)
           file_bytes[i] = text_byte(ItText, 4, i);
      1: for (int i = 0; i < PrefixLen && i < len; i++)
           file_bytes[i] = text_byte(MtmText, 4, i);
      2: for (int i = 0; i < XmLen && i < len; i++)
           file_bytes[i] = text_byte(XmText, 17, i);
      default: ;
    endcase

    if ($urandom_range(0, 2) == 0) begin
      if (len > S3mVerOffset) file_bytes[S3mVerOffset] = S3mVersion;
      for (int i = 0; i < 4 && S3mOffset + i < len; i++)
        file_bytes[S3mOffset + i] = text_byte(ScrmText, 4, i);
    end

    if (len >= SavedPosMax && $urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 3))
        0: begin  // two digits, straddling the 1..32 range
          d0  = 8'h30 + 8'($urandom_range(0, 3));
          d1  = 8'h30 + 8'($urandom_range(0, 9));
          tag = {d0, d1, "CH"};
        end
        1: begin
          d0  = 8'h30 + 8'($urandom_range(0, 9));
          d1  = 8'h30 + 8'($urandom_range(0, 9));
          tag = {d0, d1, "CH"};
        end
        2: tag = {8'h30 + 8'($urandom_range(0, 9)), "CHN"};
        default: tag = MkText;
      endcase
      for (int i = 0; i < 4; i++) file_bytes[TailStart + i] = tag[8*(3-i) +: 8];
    end

    // Break one signature byte now and then
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 3))
        0: spot = $urandom_range(0, XmLen - 1);
        1: spot = S3mVerOffset;
        2: spot = $urandom_range(S3mOffset, S3mOffset + 3);
        default: spot = $urandom_range(TailStart, TailStart + 3);
      endcase
      if (spot < len) file_bytes[spot] = file_bytes[spot] ^ 8'($urandom_range(1, 255));
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: each head format, a truncated head, one-byte files at the
    // byte extremes.
    send_text(ItText, 4);
    send_text(ItText >> 8, 3);
    send_text(MtmText, 4);
    send_text(136'hFF, 1);
    send_text(136'h00, 1);
    send_text(XmText, 17);

    // One file long enough to reach the channel tag
    build_random_file(1'b1);
    send_built_file();

    // Short random files until most of the byte budget is spent
    while (bytes_sent < MainBytes) begin
      build_random_file(1'b0);
      send_built_file();
    end

    // Last stretch with both sides always willing
    no_idling = 1'b1;
    repeat (4) begin
      build_random_file(1'b0);
      send_built_file();
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/mfs_pkg.sv
design/mfs_step.sv
design/module_format_sniffer_core.sv
bench/tb.sv
